[src/rrcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcg_pkg
// Widths, corner cell payload and the sine/cosine tables of the rotated
// rectangle corner generator.
// ----------------------------------------------------------------------------
package rrcg_pkg;

  localparam int FRAC_BITS          = 8;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int TURN_UNITS         = 23040;
  localparam int CELLS              = 4;

  localparam int POS_W  = 24;
  localparam int PIV_W  = 16;
  localparam int SCL_W  = 16;
  localparam int SIZE_W = 23;
  localparam int ANG_W  = 16;
  localparam int CRD_W  = 24;
  localparam int CIDX_W = 2;
  localparam int TRIG_W = 16;
  localparam int TRIG_FRAC = 15;

  localparam int PROD_W = SIZE_W + 1 + SCL_W;
  localparam int FX_W   = PROD_W - FRAC_BITS;
  localparam int OFFP_W = PIV_W + FX_W;
  localparam int OFF_W  = OFFP_W - FRAC_BITS;
  localparam int W_W    = OFF_W + 1;
  localparam int D_W    = OFF_W + 1;
  localparam int RP_W   = D_W + TRIG_W;
  localparam int RS_W   = RP_W + 1;
  localparam int R_W    = RS_W - TRIG_FRAC;
  localparam int SUM_W  = ((R_W > W_W) ? R_W : W_W) + 1;

  localparam int M_W    = $clog2(TURN_UNITS);
  localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
  localparam int T_W    = $clog2((TURN_UNITS - 1) * SINE_TABLE_ENTRIES + TURN_UNITS / 2 + 1);
  localparam int RCP_SH = T_W + 1;
  localparam longint unsigned RCP = (64'd1 << RCP_SH) / TURN_UNITS;
  localparam int QP_W   = RCP_SH + IDX_W + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [TRIG_W-1:0] trig_rom_t [SINE_TABLE_ENTRIES];

  typedef struct packed {
    logic                     valid;
    logic signed [D_W-1:0]    dx;
    logic signed [D_W-1:0]    dy;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic signed [W_W-1:0]    wx;
    logic signed [W_W-1:0]    wy;
    logic [CIDX_W-1:0]        index;
    logic                     last;
  } corner_t;

  function automatic logic signed [TRIG_W-1:0] quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = (r * HALF_PI_Q30 + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return TRIG_W'(sum);
  endfunction

  function automatic logic signed [TRIG_W-1:0] phase_sine(longint unsigned p);
    longint unsigned ph;
    longint unsigned quad;
    longint unsigned r;
    logic signed [TRIG_W-1:0] v;
    ph   = p % (4 * SINE_TABLE_ENTRIES);
    quad = ph / SINE_TABLE_ENTRIES;
    r    = ph % SINE_TABLE_ENTRIES;
    case (quad)
      0: v = quarter_sine(r);
      1: v = quarter_sine(SINE_TABLE_ENTRIES - r);
      2: v = -quarter_sine(r);
      default: v = -quarter_sine(SINE_TABLE_ENTRIES - r);
    endcase
    return v;
  endfunction

  function automatic trig_rom_t build_sin();
    trig_rom_t rom;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      rom[k] = phase_sine(longint'(4 * k));
    end
    return rom;
  endfunction

  function automatic trig_rom_t build_cos();
    trig_rom_t rom;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      rom[k] = phase_sine(longint'(4 * k + SINE_TABLE_ENTRIES));
    end
    return rom;
  endfunction

  localparam trig_rom_t SIN_ROM = build_sin();
  localparam trig_rom_t COS_ROM = build_cos();

endpackage

[src/rotated_rect_corner_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rect_corner_generator
// Emits the four rotated corners of each sprite rectangle.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_pos_x .. in_angle
//  out     | output    | out_valid, out_ready, out_corner_x .. out_last_corner
//
//  An item spends five setup stages, waits in a row of four corner cells and
//  leaves through two rotate stages. The one rotate datapath takes one
//  corner per cycle from the head cell while the output is not stalled. A new
//  item loads when the second cell is empty and the head cell is free or taken.
//  Reset clears all valid flags; nothing else needs clearing.
//  A stalled output holds every stage behind it; no transaction is dropped.
// ----------------------------------------------------------------------------
module rotated_rect_corner_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rrcg_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [rrcg_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [rrcg_pkg::PIV_W-1:0]    in_pivot_x,
  input  logic signed [rrcg_pkg::PIV_W-1:0]    in_pivot_y,
  input  logic signed [rrcg_pkg::SCL_W-1:0]    in_scale_x,
  input  logic signed [rrcg_pkg::SCL_W-1:0]    in_scale_y,
  input  logic        [rrcg_pkg::SIZE_W-1:0]   in_size_x,
  input  logic        [rrcg_pkg::SIZE_W-1:0]   in_size_y,
  input  logic signed [rrcg_pkg::ANG_W-1:0]    in_angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rrcg_pkg::CRD_W-1:0]    out_corner_x,
  output logic signed [rrcg_pkg::CRD_W-1:0]    out_corner_y,
  output logic        [rrcg_pkg::CIDX_W-1:0]   out_corner_index,
  output logic                                 out_last_corner
);
  import rrcg_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (CRD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(64'sd1 <<< (CRD_W - 1)));

  // stage valids and enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, r1_v_r, out_v_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en, r1_en, out_en, ld;

  corner_t cell_q [CELLS];
  corner_t cell_ld [CELLS];

  assign out_en   = !out_v_r || out_ready;
  assign r1_en    = !r1_v_r || out_en;
  assign ld       = s5_v_r && !cell_q[1].valid && (!cell_q[0].valid || r1_en);
  assign s5_en    = !s5_v_r || ld;
  assign s4_en    = !s4_v_r || s5_en;
  assign s3_en    = !s3_v_r || s4_en;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      r1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en)  s1_v_r  <= in_valid;
      if (s2_en)  s2_v_r  <= s1_v_r;
      if (s3_en)  s3_v_r  <= s2_v_r;
      if (s4_en)  s4_v_r  <= s3_v_r;
      if (s5_en)  s5_v_r  <= s4_v_r;
      if (r1_en)  r1_v_r  <= cell_q[0].valid;
      if (out_en) out_v_r <= r1_v_r;
    end
  end

  // stage 1: input capture
  logic signed [POS_W-1:0]  s1_pos_x_r, s1_pos_y_r;
  logic signed [PIV_W-1:0]  s1_piv_x_r, s1_piv_y_r;
  logic signed [SCL_W-1:0]  s1_scl_x_r, s1_scl_y_r;
  logic        [SIZE_W-1:0] s1_size_x_r, s1_size_y_r;
  logic signed [ANG_W-1:0]  s1_ang_r;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_pos_x_r  <= in_pos_x;
      s1_pos_y_r  <= in_pos_y;
      s1_piv_x_r  <= in_pivot_x;
      s1_piv_y_r  <= in_pivot_y;
      s1_scl_x_r  <= in_scale_x;
      s1_scl_y_r  <= in_scale_y;
      s1_size_x_r <= in_size_x;
      s1_size_y_r <= in_size_y;
      s1_ang_r    <= in_angle;
    end
  end

  // stage 2: scaled size, angle reduction
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic        [PROD_W-1:0] rnd_x, rnd_y;
  logic signed [ANG_W+1:0]  ang_e, ang_m;
  logic        [T_W-1:0]    t_nxt;

  always_comb begin
    prod_x = $signed({1'b0, s1_size_x_r}) * s1_scl_x_r;
    prod_y = $signed({1'b0, s1_size_y_r}) * s1_scl_y_r;
    rnd_x  = prod_x + (PROD_W'(1) << (FRAC_BITS - 1));
    rnd_y  = prod_y + (PROD_W'(1) << (FRAC_BITS - 1));
    ang_e  = (ANG_W + 2)'(s1_ang_r);
    if (ang_e < -TURN_UNITS) begin
      ang_m = ang_e + (ANG_W + 2)'(2 * TURN_UNITS);
    end else if (ang_e < 0) begin
      ang_m = ang_e + (ANG_W + 2)'(TURN_UNITS);
    end else if (ang_e >= TURN_UNITS) begin
      ang_m = ang_e - (ANG_W + 2)'(TURN_UNITS);
    end else begin
      ang_m = ang_e;
    end
    t_nxt = T_W'(ang_m[M_W-1:0]) * T_W'(SINE_TABLE_ENTRIES) + T_W'(TURN_UNITS / 2);
  end

  logic signed [POS_W-1:0] s2_pos_x_r, s2_pos_y_r;
  logic signed [PIV_W-1:0] s2_piv_x_r, s2_piv_y_r;
  logic signed [FX_W-1:0]  s2_fx_r, s2_fy_r;
  logic        [T_W-1:0]   s2_t_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_pos_x_r <= s1_pos_x_r;
      s2_pos_y_r <= s1_pos_y_r;
      s2_piv_x_r <= s1_piv_x_r;
      s2_piv_y_r <= s1_piv_y_r;
      s2_fx_r    <= rnd_x[FRAC_BITS +: FX_W];
      s2_fy_r    <= rnd_y[FRAC_BITS +: FX_W];
      s2_t_r     <= t_nxt;
    end
  end

  // stage 3: pivot offset, index estimate
  logic signed [OFFP_W-1:0] offp_x, offp_y;
  logic        [OFFP_W-1:0] offr_x, offr_y;
  logic        [QP_W-1:0]   qp;

  always_comb begin
    offp_x = s2_piv_x_r * s2_fx_r;
    offp_y = s2_piv_y_r * s2_fy_r;
    offr_x = offp_x + (OFFP_W'(1) << (FRAC_BITS - 1));
    offr_y = offp_y + (OFFP_W'(1) << (FRAC_BITS - 1));
    qp     = QP_W'(s2_t_r) * QP_W'(RCP);
  end

  logic signed [POS_W-1:0] s3_pos_x_r, s3_pos_y_r;
  logic signed [FX_W-1:0]  s3_fx_r, s3_fy_r;
  logic signed [OFF_W-1:0] s3_off_x_r, s3_off_y_r;
  logic        [T_W-1:0]   s3_t_r;
  logic        [IDX_W:0]   s3_q_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_pos_x_r <= s2_pos_x_r;
      s3_pos_y_r <= s2_pos_y_r;
      s3_fx_r    <= s2_fx_r;
      s3_fy_r    <= s2_fy_r;
      s3_off_x_r <= offr_x[FRAC_BITS +: OFF_W];
      s3_off_y_r <= offr_y[FRAC_BITS +: OFF_W];
      s3_t_r     <= s2_t_r;
      s3_q_r     <= qp[RCP_SH +: IDX_W + 1];
    end
  end

  // stage 4: index correction, pivot world position, corner deltas
  logic [T_W-1:0]   rem;
  logic [IDX_W:0]   q_fix;
  logic [IDX_W:0]   idx_w;

  always_comb begin
    rem   = s3_t_r - T_W'(T_W'(s3_q_r) * T_W'(TURN_UNITS));
    q_fix = s3_q_r + (IDX_W + 1)'(rem >= T_W'(TURN_UNITS));
    if (q_fix >= (IDX_W + 1)'(SINE_TABLE_ENTRIES)) begin
      idx_w = q_fix - (IDX_W + 1)'(SINE_TABLE_ENTRIES);
    end else begin
      idx_w = q_fix;
    end
  end

  logic [IDX_W-1:0]        s4_idx_r;
  logic signed [W_W-1:0]   s4_wx_r, s4_wy_r;
  logic signed [D_W-1:0]   s4_dx0_r, s4_dx1_r, s4_dy0_r, s4_dy1_r;

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_idx_r <= idx_w[IDX_W-1:0];
      s4_wx_r  <= W_W'(s3_pos_x_r) + W_W'(s3_off_x_r);
      s4_wy_r  <= W_W'(s3_pos_y_r) + W_W'(s3_off_y_r);
      s4_dx0_r <= -D_W'(s3_off_x_r);
      s4_dy0_r <= -D_W'(s3_off_y_r);
      s4_dx1_r <= D_W'(s3_fx_r) - D_W'(s3_off_x_r);
      s4_dy1_r <= D_W'(s3_fy_r) - D_W'(s3_off_y_r);
    end
  end

  // stage 5: sine and cosine lookup
  logic signed [TRIG_W-1:0] s5_c_r, s5_s_r;
  logic signed [W_W-1:0]    s5_wx_r, s5_wy_r;
  logic signed [D_W-1:0]    s5_dx0_r, s5_dx1_r, s5_dy0_r, s5_dy1_r;

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_c_r   <= COS_ROM[s4_idx_r];
      s5_s_r   <= SIN_ROM[s4_idx_r];
      s5_wx_r  <= s4_wx_r;
      s5_wy_r  <= s4_wy_r;
      s5_dx0_r <= s4_dx0_r;
      s5_dx1_r <= s4_dx1_r;
      s5_dy0_r <= s4_dy0_r;
      s5_dy1_r <= s4_dy1_r;
    end
  end

  // corner cells: load four corners at once, shift toward the head
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      cell_ld[i].valid = 1'b1;
      cell_ld[i].dx    = (i == 1 || i == 2) ? s5_dx1_r : s5_dx0_r;
      cell_ld[i].dy    = (i >= 2) ? s5_dy1_r : s5_dy0_r;
      cell_ld[i].c     = s5_c_r;
      cell_ld[i].s     = s5_s_r;
      cell_ld[i].wx    = s5_wx_r;
      cell_ld[i].wy    = s5_wy_r;
      cell_ld[i].index = CIDX_W'(i);
      cell_ld[i].last  = (i == CELLS - 1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      corner_t nb;
      if (gi == CELLS - 1) begin : g_tail
        assign nb = '0;
      end else begin : g_mid
        assign nb = cell_q[gi + 1];
      end
      rrcg_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      (ld),
        .sh      (r1_en),
        .ld_data (cell_ld[gi]),
        .nb_data (nb),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  // rotate stage 1: products
  logic signed [RP_W-1:0]  r1_pxc_r, r1_pys_r, r1_pxs_r, r1_pyc_r;
  logic signed [W_W-1:0]   r1_wx_r, r1_wy_r;
  logic [CIDX_W-1:0]       r1_index_r;
  logic                    r1_last_r;

  always_ff @(posedge clk) begin
    if (r1_en) begin
      r1_pxc_r   <= cell_q[0].dx * cell_q[0].c;
      r1_pys_r   <= cell_q[0].dy * cell_q[0].s;
      r1_pxs_r   <= cell_q[0].dx * cell_q[0].s;
      r1_pyc_r   <= cell_q[0].dy * cell_q[0].c;
      r1_wx_r    <= cell_q[0].wx;
      r1_wy_r    <= cell_q[0].wy;
      r1_index_r <= cell_q[0].index;
      r1_last_r  <= cell_q[0].last;
    end
  end

  // rotate stage 2: round, translate, saturate
  logic [RS_W-1:0]         rs_x, rs_y;
  logic signed [R_W-1:0]   rx, ry;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [CRD_W-1:0] cx_nxt, cy_nxt;

  always_comb begin
    rs_x  = RS_W'(r1_pxc_r) - RS_W'(r1_pys_r) + (RS_W'(1) << (TRIG_FRAC - 1));
    rs_y  = RS_W'(r1_pxs_r) + RS_W'(r1_pyc_r) + (RS_W'(1) << (TRIG_FRAC - 1));
    rx    = rs_x[TRIG_FRAC +: R_W];
    ry    = rs_y[TRIG_FRAC +: R_W];
    sum_x = SUM_W'(r1_wx_r) + SUM_W'(rx);
    sum_y = SUM_W'(r1_wy_r) + SUM_W'(ry);
    if (sum_x > SAT_HI) begin
      cx_nxt = SAT_HI[CRD_W-1:0];
    end else if (sum_x < SAT_LO) begin
      cx_nxt = SAT_LO[CRD_W-1:0];
    end else begin
      cx_nxt = sum_x[CRD_W-1:0];
    end
    if (sum_y > SAT_HI) begin
      cy_nxt = SAT_HI[CRD_W-1:0];
    end else if (sum_y < SAT_LO) begin
      cy_nxt = SAT_LO[CRD_W-1:0];
    end else begin
      cy_nxt = sum_y[CRD_W-1:0];
    end
  end

  logic signed [CRD_W-1:0] out_cx_r, out_cy_r;
  logic [CIDX_W-1:0]       out_index_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_cx_r    <= cx_nxt;
      out_cy_r    <= cy_nxt;
      out_index_r <= r1_index_r;
      out_last_r  <= r1_last_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_corner_x     = out_cx_r;
  assign out_corner_y     = out_cy_r;
  assign out_corner_index = out_index_r;
  assign out_last_corner  = out_last_r;

endmodule

[src/rrcg_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcg_cell
// One corner cell: loads a corner in parallel or takes its neighbor's corner.
// ----------------------------------------------------------------------------
module rrcg_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  logic              sh,
  input  rrcg_pkg::corner_t ld_data,
  input  rrcg_pkg::corner_t nb_data,
  output rrcg_pkg::corner_t q
);
  import rrcg_pkg::*;

  corner_t q_r;
  corner_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ld) begin
      q_nxt = ld_data;
    end else if (sh) begin
      q_nxt = nb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
